// ----- hdl/tilt_and_shake_detector_core_macros.svh -----
// Assertion macros for the tilt and shake detector core.
// Included by the top level; needs clk and rst_n in scope.
`ifndef TILT_AND_SHAKE_DETECTOR_CORE_MACROS_SVH
`define TILT_AND_SHAKE_DETECTOR_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define TASD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define TASD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tasd_pkg.sv -----
// Shared types, constants and the arctangent table of the tilt and shake detector.
// No dependencies.
package tasd_pkg;

  // CORDIC datapath widths: vector lanes and angle accumulator (2^-20 degree).
  localparam int VEC_W    = 27;
  localparam int ANG_W    = 30;
  localparam int ACC_FRAC = 20;
  localparam int ATAN_LEN = 24;

  localparam logic signed [ANG_W-1:0] DEG180 = 30'sd188743680;
  localparam logic signed [ANG_W-1:0] DEG90  = 30'sd94371840;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SHAKE_ENABLE    = 3'd0;
  localparam logic [2:0] CFG_SHAKE_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_REARM_THRESHOLD = 3'd2;
  localparam logic [2:0] CFG_COOLDOWN_US     = 3'd3;
  localparam logic [2:0] CFG_TILT_THRESHOLD  = 3'd4;
  localparam logic [2:0] CFG_DEBOUNCE_COUNT  = 3'd5;

  // Shake and tilt codes.
  localparam logic [1:0] SHAKE_NONE  = 2'd0;
  localparam logic [1:0] SHAKE_LEFT  = 2'd1;
  localparam logic [1:0] SHAKE_RIGHT = 2'd2;
  localparam logic [2:0] TILT_LEVEL  = 3'd0;
  localparam logic [2:0] TILT_LEFT   = 3'd1;
  localparam logic [2:0] TILT_RIGHT  = 3'd2;
  localparam logic [2:0] TILT_FRONT  = 3'd3;
  localparam logic [2:0] TILT_BACK   = 3'd4;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [15:0]        elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic               shake_event;
    logic [1:0]         shake_direction;
    logic [2:0]         tilt_direction;
  } out_word_t;

  // One vector in flight through the CORDIC chain; tag marks the pitch pass.
  typedef struct packed {
    logic                    tag;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_vec_t;

  // atan(2^-i) in units of 2^-20 degree.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/tilt_and_shake_detector_core.sv -----
// Top level of the tilt and shake detector: control, square root, shake and tilt logic.
// Depends on tasd_pkg, tasd_chain and the assertion macro header.
`include "tilt_and_shake_detector_core_macros.svh"

// Each sample word yields one result word. The roll pass runs through the
// CORDIC cell row while a one-bit-per-cycle square root forms sqrt(x*x+z*z),
// then the pitch pass goes through the same row. One word is in work at a
// time; a finished result waits in the output register while the next sample
// is accepted.
module tilt_and_shake_detector_core import tasd_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [19:0] cfg_wdata
);

  localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int SH     = ACC_FRAC - ANGLE_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_LAUNCH, S_ROOT, S_WROLL, S_PLAUNCH, S_WPITCH, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic        shake_en_r;
  logic [14:0] shake_thr_r, rearm_thr_r;
  logic [19:0] cooldown_r;
  logic [13:0] tilt_thr_r;
  logic [3:0]  debounce_r;

  // Detector state.
  logic        armed_r;
  logic [1:0]  last_shake_r;
  logic [19:0] tst_r;
  logic [2:0]  last_cls_r;
  logic [3:0]  stable_r;

  // Sample and working registers.
  in_word_t                smp_r;
  logic [31:0]             sqx_r, sqz_r;
  logic [31:0]             rem_r, res_r, bit_r;
  logic signed [19:0]      roll_r, pitch_r;
  logic                    roll_done_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic        ch_in_vld, ch_out_vld;
  cordic_vec_t ch_in_vec, ch_out_vec;

  // Pre-rotation of a vector into the right half plane and scaling by 256.
  function automatic cordic_vec_t launch_vec(input logic signed [17:0] y,
                                             input logic signed [17:0] x,
                                             input logic tag);
    cordic_vec_t v;
    v.tag = tag;
    v.z   = '0;
    v.x   = VEC_W'(x) <<< 8;
    v.y   = VEC_W'(y) <<< 8;
    if (x[17]) begin
      v.z = y[17] ? -DEG180 : DEG180;
      v.x = -(VEC_W'(x) <<< 8);
      v.y = -(VEC_W'(y) <<< 8);
    end
    return v;
  endfunction

  // Clamp to the limit and round half away from zero to output units.
  function automatic logic signed [19:0] finish_angle(input logic signed [ANG_W-1:0] z,
                                                      input logic signed [ANG_W-1:0] lim);
    logic signed [ANG_W-1:0] zc, mag, r;
    logic signed [19:0]      rt;
    zc = z;
    if (z > lim) zc = lim;
    else if (z < -lim) zc = -lim;
    mag = zc[ANG_W-1] ? -zc : zc;
    r   = (mag + (ANG_W'(1) <<< (SH - 1))) >>> SH;
    rt  = r[19:0];
    return zc[ANG_W-1] ? -rt : rt;
  endfunction

  // Chain launch select: roll pass from (x, z), pitch pass from (y, horizontal).
  always_comb begin
    ch_in_vld = (state_r == S_LAUNCH) || (state_r == S_PLAUNCH);
    if (state_r == S_PLAUNCH) begin
      ch_in_vec = launch_vec(18'(smp_r.accel_y), {1'b0, res_r[16:0]}, 1'b1);
    end else begin
      ch_in_vec = launch_vec(18'(smp_r.accel_x), 18'(smp_r.accel_z), 1'b0);
    end
  end

  tasd_chain #(.STEPS(NSTEPS)) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (ch_in_vld),
    .in_vec (ch_in_vec),
    .out_vld(ch_out_vld),
    .out_vec(ch_out_vec)
  );

  // Square root step, shake and tilt decisions.
  logic [31:0]        trial;
  logic [20:0]        tst_sum;
  logic [19:0]        tst_nxt;
  logic               armed_nxt, event_nxt;
  logic [1:0]         shake_nxt;
  logic signed [16:0] ax17, thr17, rthr17;
  logic signed [19:0] t20;
  logic [2:0]         cls;
  logic [2:0]         last_cls_nxt;
  logic [3:0]         stable_nxt;
  logic [2:0]         tilt_nxt;
  logic signed [ANG_W-1:0] roll_z, pitch_z;

  always_comb begin
    trial = res_r + bit_r;

    // Special angle for a zero first operand.
    roll_z = ch_out_vec.z;
    if (smp_r.accel_x == '0) roll_z = smp_r.accel_z[15] ? DEG180 : '0;
    pitch_z = (smp_r.accel_y == '0) ? '0 : ch_out_vec.z;

    // Saturating time since the last trigger.
    tst_sum = {1'b0, tst_r} + {5'b0, smp_r.elapsed_us};
    tst_nxt = tst_sum[20] ? 20'hFFFFF : tst_sum[19:0];

    ax17   = 17'(smp_r.accel_x);
    thr17  = {2'b0, shake_thr_r};
    rthr17 = {2'b0, rearm_thr_r};
    armed_nxt = armed_r;
    shake_nxt = last_shake_r;
    event_nxt = 1'b0;
    if (armed_r && shake_en_r) begin
      if (ax17 > thr17) begin
        armed_nxt = 1'b0;
        shake_nxt = SHAKE_LEFT;
        tst_nxt   = '0;
        event_nxt = 1'b1;
      end else if (ax17 < -thr17) begin
        armed_nxt = 1'b0;
        shake_nxt = SHAKE_RIGHT;
        tst_nxt   = '0;
        event_nxt = 1'b1;
      end
    end
    if (!armed_nxt && (tst_nxt > cooldown_r) && (ax17 > -rthr17) && (ax17 < rthr17)) begin
      armed_nxt = 1'b1;
    end

    // Tilt class with priority roll over pitch.
    t20 = {6'b0, tilt_thr_r};
    priority if (roll_r < -t20) cls = TILT_LEFT;
    else if (roll_r > t20)      cls = TILT_RIGHT;
    else if (pitch_r > t20)     cls = TILT_FRONT;
    else if (pitch_r < -t20)    cls = TILT_BACK;
    else                        cls = TILT_LEVEL;

    last_cls_nxt = last_cls_r;
    stable_nxt   = stable_r;
    if (cls == last_cls_r) begin
      if (stable_r < debounce_r) stable_nxt = stable_r + 4'd1;
    end else begin
      last_cls_nxt = cls;
      stable_nxt   = 4'd1;
    end
    tilt_nxt = (stable_nxt >= debounce_r) ? cls : TILT_LEVEL;
  end

  // Control, working registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      shake_en_r   <= 1'b0;
      shake_thr_r  <= 15'd12000;
      rearm_thr_r  <= 15'd3000;
      cooldown_r   <= 20'd300000;
      tilt_thr_r   <= 14'd2560;
      debounce_r   <= 4'd3;
      armed_r      <= 1'b1;
      last_shake_r <= SHAKE_NONE;
      tst_r        <= '0;
      last_cls_r   <= TILT_LEVEL;
      stable_r     <= '0;
      roll_done_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SHAKE_ENABLE:    shake_en_r  <= cfg_wdata[0];
          CFG_SHAKE_THRESHOLD: shake_thr_r <= cfg_wdata[14:0];
          CFG_REARM_THRESHOLD: rearm_thr_r <= cfg_wdata[14:0];
          CFG_COOLDOWN_US:     cooldown_r  <= cfg_wdata;
          CFG_TILT_THRESHOLD:  tilt_thr_r  <= cfg_wdata[13:0];
          CFG_DEBOUNCE_COUNT:  debounce_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      // The finish state refills the output register itself.
      if (out_valid_r && !out_stall && state_r != S_FIN) out_valid_r <= 1'b0;

      if (ch_out_vld && !ch_out_vec.tag) roll_done_r <= 1'b1;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_LAUNCH;
        end
        S_LAUNCH: begin
          roll_done_r <= 1'b0;
          state_r     <= S_ROOT;
        end
        S_ROOT: begin
          if (bit_r[0]) state_r <= S_WROLL;
        end
        S_WROLL: begin
          if (roll_done_r) state_r <= S_PLAUNCH;
        end
        S_PLAUNCH: begin
          state_r <= S_WPITCH;
        end
        S_WPITCH: begin
          if (ch_out_vld && ch_out_vec.tag) state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            armed_r      <= armed_nxt;
            last_shake_r <= shake_nxt;
            tst_r        <= tst_nxt;
            last_cls_r   <= last_cls_nxt;
            stable_r     <= stable_nxt;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end

    // Payload registers.
    if (state_r == S_IDLE && in_valid) smp_r <= in_data;
    if (state_r == S_LAUNCH) begin
      sqx_r <= 32'(smp_r.accel_x * smp_r.accel_x);
      sqz_r <= 32'(smp_r.accel_z * smp_r.accel_z);
    end
    if (state_r == S_ROOT) begin
      if (bit_r == 32'h4000_0000) begin
        // First root step works on the fresh sum of squares.
        if ((sqx_r + sqz_r) >= bit_r) begin
          rem_r <= sqx_r + sqz_r - bit_r;
          res_r <= bit_r;
        end else begin
          rem_r <= sqx_r + sqz_r;
          res_r <= '0;
        end
      end else if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end else begin
      bit_r <= 32'h4000_0000;
    end
    if (ch_out_vld && !ch_out_vec.tag) roll_r  <= finish_angle(roll_z, DEG180);
    if (ch_out_vld && ch_out_vec.tag)  pitch_r <= finish_angle(pitch_z, DEG90);
    if (state_r == S_FIN && (!out_valid_r || !out_stall)) begin
      out_r.pitch_angle     <= pitch_r[14:0];
      out_r.roll_angle      <= roll_r[15:0];
      out_r.shake_event     <= event_nxt;
      out_r.shake_direction <= shake_nxt;
      out_r.tilt_direction  <= tilt_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Assertions.
  `TASD_ASSERT_SAME(a_pitch_in_wait, ch_out_vld && ch_out_vec.tag, state_r == S_WPITCH,
    "pitch vector left the chain outside its wait state")
  `TASD_ASSERT_SAME(a_roll_before_pitch, state_r == S_PLAUNCH, roll_done_r,
    "pitch pass launched before roll finished")
  `TASD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
    "accepted word did not make the block busy")

endmodule

// ----- hdl/tasd_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation with a fixed shift.
// Depends on tasd_pkg.
module tasd_cell import tasd_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  cordic_vec_t in_vec,
  output logic        out_vld,
  output cordic_vec_t out_vec
);

  logic                    vld_r;
  cordic_vec_t             vec_r, vec_nxt;
  logic signed [VEC_W-1:0] xs, ys;
  logic                    y_pos;
  logic signed [ANG_W-1:0] atan_c;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    xs     = in_vec.x >>> SHIFT;
    ys     = in_vec.y >>> SHIFT;
    y_pos  = !in_vec.y[VEC_W-1] && (in_vec.y != '0);
    atan_c = atan_entry(5'(SHIFT));
    vec_nxt.tag = in_vec.tag;
    if (y_pos) begin
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
      vec_nxt.z = in_vec.z + atan_c;
    end else begin
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
      vec_nxt.z = in_vec.z - atan_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    vec_r <= vec_nxt;
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

// ----- hdl/tasd_chain.sv -----
// Row of CORDIC cells; a vector moves one cell per cycle.
// Depends on tasd_pkg and tasd_cell.
module tasd_chain import tasd_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  cordic_vec_t in_vec,
  output logic        out_vld,
  output cordic_vec_t out_vec
);

  logic        vld [0:STEPS];
  cordic_vec_t vec [0:STEPS];

  assign vld[0] = in_vld;
  assign vec[0] = in_vec;

  // Cell i shifts by i.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    tasd_cell #(.SHIFT(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (vld[i]),
      .in_vec (vec[i]),
      .out_vld(vld[i+1]),
      .out_vec(vec[i+1])
    );
  end

  assign out_vld = vld[STEPS];
  assign out_vec = vec[STEPS];

endmodule
